[rtl/npbw_pkg.sv]
// Shared types and constants for the nearest points blend weights block.
package npbw_pkg;
    localparam int MAX_POINTS = 16;
    localparam int CoordW = 24;
    localparam int DistW  = 24;
    localparam int WghtW  = 16;
    localparam int IdxW   = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_POINT_COUNT  = 2'd0;
    localparam logic [1:0] REG_MAX_SPREAD   = 2'd1;
    localparam logic [1:0] REG_NEAREST_ONLY = 2'd2;

    typedef struct packed {
        logic                      operation;
        logic [IdxW-1:0]           point_index;
        logic signed [CoordW-1:0]  coord_x;
        logic signed [CoordW-1:0]  coord_y;
        logic signed [CoordW-1:0]  coord_z;
    } t_in_item;

    typedef struct packed {
        logic [IdxW-1:0]  terrain_index;
        logic [WghtW-1:0] weight;
        logic [DistW-1:0] distance;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [23:0] data;
    } t_cfg_item;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [47:0] den;
    } t_div_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST_SETUP,
        ST_DIST_SQ,
        ST_DIST_ROOT,
        ST_DIST_SAVE,
        ST_SEL_SCAN,
        ST_SEL_PICK,
        ST_RAW_DIV,
        ST_RAW_WAIT,
        ST_NORM_DIV,
        ST_NORM_WAIT,
        ST_EMIT
    } t_state;
endpackage

[rtl/npbw_if.sv]
// Valid/ready channel interface carrying one payload type.
interface npbw_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/npbw_div.sv]
// Shared restoring divider, one quotient bit per cycle, 48 by 48 bits.
module npbw_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  npbw_pkg::t_div_req   i_req,
    output logic                 o_done,
    output logic [47:0]          o_quot
);
    import npbw_pkg::*;

    logic [47:0] r_rem, n_rem;
    logic [47:0] r_quot, n_quot;
    logic [47:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [48:0] w_trial;

    // One shift and subtract step per cycle.
    always_comb begin
        w_trial = {r_rem, r_quot[47]} - {1'b0, r_den};
        if (!w_trial[48]) begin
            n_rem = w_trial[47:0];
            n_quot = {r_quot[46:0], 1'b1};
        end else begin
            n_rem = {r_rem[46:0], r_quot[47]};
            n_quot = {r_quot[46:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd47;
                r_rem  <= '0;
                r_quot <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
endmodule

[rtl/nearest_points_blend_weights.sv]
// Top level of the nearest points blend weights block.
// Channel    | Dir | Payload
// in_ch      | in  | operation, point_index, coord_x/y/z
// out_ch     | out | terrain_index, weight, distance, last
// cfg_ch     | in  | register index, write data
// A load item is written into the point store from idle. A query finds each point's distance
// (three squares, a 25-step square root), orders the points by selection sort, then on the
// 48-step divider computes raw weights for the kept points and normalizes each result.
// Nearest-only mode skips both division passes.
// Reset is synchronous and active low; it returns control to idle and sets the configuration registers to defaults.
// A result waits in the output register while the consumer stalls; no item is taken then.
module nearest_points_blend_weights (
    input  logic i_clk,
    input  logic i_rst_n,
    npbw_if.sink   in_ch,
    npbw_if.source out_ch,
    npbw_if.sink   cfg_ch
);
    import npbw_pkg::*;

    localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // Configuration registers.
    logic [4:0]  r_point_count;
    logic [23:0] r_max_spread;
    logic        r_nearest_only;

    // Stores.
    logic signed [CoordW-1:0] r_px [MAX_POINTS];
    logic signed [CoordW-1:0] r_py [MAX_POINTS];
    logic signed [CoordW-1:0] r_pz [MAX_POINTS];
    logic [DistW-1:0]  r_dist [MAX_POINTS];
    logic [PW-1:0]     r_order [MAX_POINTS];
    logic [MAX_POINTS-1:0] r_taken;
    logic [WghtW:0]    r_raw [MAX_POINTS];
    logic [23:0]       r_weight_sum;

    t_state r_state, n_state;
    logic signed [CoordW-1:0] r_qx, r_qy, r_qz;
    logic [CW-1:0]  r_n;
    logic [CW-1:0]  r_i;
    logic [CW-1:0]  r_j;
    logic [CW-1:0]  r_kept;
    logic [1:0]     r_axis;
    logic [49:0]    r_acc;
    logic [49:0]    r_rad, r_root, r_bit;
    logic [DistW-1:0] r_best;
    logic [PW-1:0]  r_best_idx;
    logic           r_best_ok;
    logic [DistW-1:0] r_closest;
    logic           r_out_valid;
    t_out_item      r_out;
    t_div_req       w_div;
    logic           w_div_done;
    logic [47:0]    w_quot;

    logic [CW-1:0]  w_cnt;
    logic signed [CoordW:0] w_diff;
    logic [47:0]    w_sq;
    logic [50:0]    w_trial;
    logic [PW-1:0]  w_i;
    logic [PW-1:0]  w_j;
    logic [24:0]    w_excess;
    logic [PW-1:0]  w_oidx;
    logic           w_raw_end;
    logic           w_out_load;

    npbw_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // Clamp the point count into the table size; a count of zero becomes one.
    always_comb begin
        if (r_point_count == 5'd0) begin
            w_cnt = CW'(1);
        end else if (32'(r_point_count) > MAX_POINTS) begin
            w_cnt = CW'(MAX_POINTS);
        end else begin
            w_cnt = CW'(r_point_count);
        end
    end

    assign w_i = r_i[PW-1:0];
    assign w_j = r_j[PW-1:0];
    assign w_oidx = r_order[w_i];

    // One squared coordinate difference per cycle.
    always_comb begin
        unique case (r_axis)
            2'd0: w_diff = (CoordW+1)'(r_px[w_i]) - (CoordW+1)'(r_qx);
            2'd1: w_diff = (CoordW+1)'(r_py[w_i]) - (CoordW+1)'(r_qy);
            default: w_diff = (CoordW+1)'(r_pz[w_i]) - (CoordW+1)'(r_qz);
        endcase
        w_sq = 48'(w_diff * w_diff);
    end

    assign w_trial = {1'b0, r_rad} - {1'b0, r_root + r_bit};
    assign w_excess = {1'b0, r_dist[w_oidx]} - {1'b0, r_closest};

    // The raw weight pass ends when every point is kept or the next one is too far.
    assign w_raw_end = (r_kept == r_n) ||
                       (r_kept != '0 && w_excess > {1'b0, r_max_spread});

    // A result is loaded into the output register.
    assign w_out_load = ((r_state == ST_RAW_DIV) && r_nearest_only) ||
                        ((r_state == ST_EMIT) && (!r_out_valid || out_ch.ready));

    // Divider requests for raw and normalized weights.
    always_comb begin
        w_div = '0;
        if (r_state == ST_RAW_DIV && !r_nearest_only && !w_raw_end) begin
            w_div.start = 1'b1;
            w_div.num = 48'h1000000;
            w_div.den = 48'(w_excess) + 48'(w_excess) + 48'd256;
        end else if (r_state == ST_NORM_DIV) begin
            w_div.start = 1'b1;
            w_div.num = {15'd0, r_raw[w_i], 16'd0};
            w_div.den = {24'd0, r_weight_sum};
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_ch.valid && in_ch.ready && in_ch.data.operation == OP_QUERY) begin
                n_state = ST_DIST_SETUP;
            end
            ST_DIST_SETUP: n_state = ST_DIST_SQ;
            ST_DIST_SQ: if (r_axis == 2'd2) begin
                n_state = ST_DIST_ROOT;
            end
            ST_DIST_ROOT: if (r_bit == '0) begin
                n_state = ST_DIST_SAVE;
            end
            ST_DIST_SAVE: n_state = (r_i + CW'(1) == r_n) ? ST_SEL_SCAN : ST_DIST_SETUP;
            ST_SEL_SCAN: if (r_j + CW'(1) == r_n) begin
                n_state = ST_SEL_PICK;
            end
            ST_SEL_PICK: begin
                if (r_i + CW'(1) == r_n) begin
                    n_state = ST_RAW_DIV;
                end else begin
                    n_state = ST_SEL_SCAN;
                end
            end
            ST_RAW_DIV: begin
                if (r_nearest_only) begin
                    n_state = ST_IDLE;
                end else if (w_raw_end) begin
                    n_state = ST_NORM_DIV;
                end else begin
                    n_state = ST_RAW_WAIT;
                end
            end
            ST_RAW_WAIT: if (w_div_done) begin
                n_state = ST_RAW_DIV;
            end
            ST_NORM_DIV: n_state = ST_NORM_WAIT;
            ST_NORM_WAIT: if (w_div_done) begin
                n_state = ST_EMIT;
            end
            ST_EMIT: if (!r_out_valid || out_ch.ready) begin
                n_state = (r_i + CW'(1) == r_kept) ? ST_IDLE : ST_NORM_DIV;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the control.
    assign in_ch.ready = (r_state == ST_IDLE) && !r_out_valid;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_out_valid;
    assign out_ch.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_point_count  <= 5'd16;
            r_max_spread   <= 24'd1280;
            r_nearest_only <= 1'b0;
            r_weight_sum   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_ch.valid) begin
                unique case (cfg_ch.data.index)
                    REG_POINT_COUNT:  r_point_count  <= cfg_ch.data.data[4:0];
                    REG_MAX_SPREAD:   r_max_spread   <= cfg_ch.data.data;
                    REG_NEAREST_ONLY: r_nearest_only <= cfg_ch.data.data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: if (in_ch.valid && in_ch.ready) begin
                    if (in_ch.data.operation == OP_LOAD) begin
                        if (32'(in_ch.data.point_index) < MAX_POINTS) begin
                            r_px[PW'(in_ch.data.point_index)] <= in_ch.data.coord_x;
                            r_py[PW'(in_ch.data.point_index)] <= in_ch.data.coord_y;
                            r_pz[PW'(in_ch.data.point_index)] <= in_ch.data.coord_z;
                        end
                    end else begin
                        r_qx <= in_ch.data.coord_x;
                        r_qy <= in_ch.data.coord_y;
                        r_qz <= in_ch.data.coord_z;
                        r_n  <= w_cnt;
                        r_i  <= '0;
                    end
                end
                ST_DIST_SETUP: begin
                    r_axis <= 2'd0;
                    r_acc  <= '0;
                end
                ST_DIST_SQ: begin
                    r_axis <= r_axis + 2'd1;
                    if (r_axis == 2'd2) begin
                        r_rad  <= r_acc + 50'(w_sq);
                        r_root <= '0;
                        r_bit  <= 50'd1 << 48;
                    end else begin
                        r_acc <= r_acc + 50'(w_sq);
                    end
                end
                ST_DIST_ROOT: if (r_bit != '0) begin
                    if (!w_trial[50]) begin
                        r_rad  <= w_trial[49:0];
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                ST_DIST_SAVE: begin
                    r_dist[w_i] <= (r_root > 50'hFFFFFF) ? 24'hFFFFFF : r_root[23:0];
                    if (r_i + CW'(1) == r_n) begin
                        r_i <= '0;
                        r_j <= '0;
                        r_taken <= '0;
                        r_best_ok <= 1'b0;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                // Selection sort: scan for the smallest untaken entry.
                ST_SEL_SCAN: begin
                    if (!r_taken[w_j] && (!r_best_ok || r_dist[w_j] < r_best)) begin
                        r_best <= r_dist[w_j];
                        r_best_idx <= w_j;
                        r_best_ok <= 1'b1;
                    end
                    r_j <= r_j + CW'(1);
                end
                ST_SEL_PICK: begin
                    r_order[w_i] <= r_best_idx;
                    r_taken[r_best_idx] <= 1'b1;
                    if (r_i == '0) begin
                        r_closest <= r_best;
                    end
                    r_best_ok <= 1'b0;
                    r_j <= '0;
                    if (r_i + CW'(1) == r_n) begin
                        r_i <= '0;
                        r_kept <= '0;
                        r_weight_sum <= '0;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                ST_RAW_DIV: begin
                    if (r_nearest_only) begin
                        r_out.terrain_index <= IdxW'(r_order[0]);
                        r_out.weight <= 16'hFFFF;
                        r_out.distance <= r_closest;
                        r_out.last <= 1'b1;
                    end else if (w_raw_end) begin
                        r_i <= '0;
                    end
                end
                ST_RAW_WAIT: if (w_div_done) begin
                    r_raw[w_i] <= w_quot[WghtW:0];
                    r_weight_sum <= r_weight_sum + 24'(w_quot[WghtW:0]);
                    r_kept <= r_kept + CW'(1);
                    r_i <= r_i + CW'(1);
                end
                ST_NORM_WAIT: ;
                ST_EMIT: if (!r_out_valid || out_ch.ready) begin
                    r_out.terrain_index <= IdxW'(w_oidx);
                    r_out.weight <= (w_quot > 48'hFFFF) ? 16'hFFFF : w_quot[15:0];
                    r_out.distance <= r_dist[w_oidx];
                    r_out.last <= (r_i + CW'(1) == r_kept);
                    r_i <= r_i + CW'(1);
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // No item is taken while a query is in progress.
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_ch.ready)
        else $error("input accepted while busy");
    // A query always keeps at least the closest point.
    a_kept_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM_DIV) |-> (r_kept != '0))
        else $error("no kept point");
    // The weight sum is never zero when normalizing.
    a_sum_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM_DIV) |-> (r_weight_sum != '0))
        else $error("zero weight sum");
`endif
endmodule
